[design/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Opcodes and the side-band record that rides along the divider pipeline of
// the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  // operation codes carried in the request
  typedef enum logic [3:0] {
    FN_ADD  = 4'd0,
    FN_ADDS = 4'd1,
    FN_SUB  = 4'd2,
    FN_SUBS = 4'd3,
    FN_MUL  = 4'd4,
    FN_MULS = 4'd5,
    FN_DIV  = 4'd6,
    FN_DIVS = 4'd7,
    FN_CONJ = 4'd8,
    FN_EQ   = 4'd9
  } cau_func_t;

  // result bookkeeping that travels beside the quotient bits
  typedef struct packed {
    logic               is_div;     // result comes from the quotient
    logic               neg_re;     // sign of the real quotient
    logic               neg_im;     // sign of the imaginary quotient
    logic signed [15:0] res_re;     // final value when not a quotient
    logic signed [15:0] res_im;
    logic               is_equal;
    logic               div_zero;
    logic               overflow;
  } cau_side_t;

endpackage

`default_nettype wire

[design/cau_div_step.sv]
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring-division stage for both quotient parts: compares the
// remainders with the shifted divisor, subtracts and sets one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_step #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 32,
  parameter int QW    = 17,
  parameter int SHIFT = 0
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  cau_pkg::cau_side_t     in_side,
  input  wire [NUM_W-1:0]        in_rem_re,
  input  wire [NUM_W-1:0]        in_rem_im,
  input  wire [DEN_W-1:0]        in_den,
  input  wire [QW:0]             in_q_re,
  input  wire [QW:0]             in_q_im,
  output logic                   out_valid,
  input  wire                    out_ready,
  output cau_pkg::cau_side_t     out_side,
  output logic [NUM_W-1:0]       out_rem_re,
  output logic [NUM_W-1:0]       out_rem_im,
  output logic [DEN_W-1:0]       out_den,
  output logic [QW:0]            out_q_re,
  output logic [QW:0]            out_q_im
);
  import cau_pkg::*;

  localparam int CW = (NUM_W > DEN_W + SHIFT) ? NUM_W : DEN_W + SHIFT;

  logic [CW-1:0]    dsh;
  logic [CW-1:0]    rx_re, rx_im;
  logic [CW-1:0]    df_re, df_im;
  logic             ge_re, ge_im;
  logic [NUM_W-1:0] rem_re_next, rem_im_next;
  logic [QW:0]      q_re_next, q_im_next;

  assign in_ready = !out_valid || out_ready;

  // trial subtract of the shifted divisor
  always_comb begin
    dsh   = CW'(in_den) << SHIFT;
    rx_re = CW'(in_rem_re);
    rx_im = CW'(in_rem_im);
    ge_re = rx_re >= dsh;
    ge_im = rx_im >= dsh;
    df_re = rx_re - dsh;
    df_im = rx_im - dsh;
    rem_re_next = ge_re ? NUM_W'(df_re) : in_rem_re;
    rem_im_next = ge_im ? NUM_W'(df_im) : in_rem_im;
    q_re_next = in_q_re;
    q_im_next = in_q_im;
    q_re_next[SHIFT] = ge_re;
    q_im_next[SHIFT] = ge_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_side   <= in_side;
      out_rem_re <= rem_re_next;
      out_rem_im <= rem_im_next;
      out_den    <= in_den;
      out_q_re   <= q_re_next;
      out_q_im   <= q_im_next;
    end
  end

endmodule

`default_nettype wire

[design/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex-number ALU on signed fixed point: add, subtract, multiply, divide
// (complex and scalar forms), conjugate and equality, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

// The unit takes one request per clock while s_tready is high and returns one
// result per request, in order. Every request, whatever its opcode, runs the
// same pipeline: input register, product stage, sum stage, divide setup, 18
// restoring division stages (one quotient bit each, the first detecting a
// quotient too large for 17 bits) and the output register. The depth is set
// by the bit-per-stage divider. Backpressure stalls only the stages that hold
// data; empty stages keep filling while a result waits at the output.

module complex_arith_unit #(
  parameter int FRAC_BITS = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // func[3:0], a_re[19:4], a_im[35:20], b_re[51:36], b_im[67:52],
  // scalar[83:68], zero [87:84]
  input  wire  [87:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // res_re[15:0], res_im[31:16], is_equal[32], div_zero[33], overflow[34],
  // zero [39:35]
  output logic [39:0] m_tdata
);
  import cau_pkg::*;

  localparam int DEN_W = 32;
  localparam int QW    = 17;
  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int NDIV  = QW + 1;
  localparam logic [33:0] RND = (34'd1 << FRAC_BITS) - 34'd1;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) return 16'sd32767;
    if (v < -34'sd32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic logic is_sat(input logic signed [33:0] v);
    return (v > 34'sd32767) || (v < -34'sd32768);
  endfunction

  // ---------------- stage 1: input register
  logic               v1, rdy1, rdy2, rdy3, rdy4;
  cau_func_t          fn1;
  logic signed [15:0] ar1, ai1, br1, bi1, sc1;

  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      fn1 <= cau_func_t'(s_tdata[3:0]);
      ar1 <= s_tdata[19:4];
      ai1 <= s_tdata[35:20];
      br1 <= s_tdata[51:36];
      bi1 <= s_tdata[67:52];
      sc1 <= s_tdata[83:68];
    end
  end

  // ---------------- stage 2: products
  logic               v2;
  cau_func_t          fn2;
  logic signed [15:0] ar2, ai2, br2, bi2, sc2, mx1;
  logic signed [31:0] pa2, pb2, pc2, pd2, pe2, pf2;

  assign rdy2 = !v2 || rdy3;
  assign mx1  = (fn1 == FN_MULS) ? sc1 : br1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      fn2 <= fn1;
      ar2 <= ar1;
      ai2 <= ai1;
      br2 <= br1;
      bi2 <= bi1;
      sc2 <= sc1;
      pa2 <= ar1 * mx1;
      pb2 <= ai1 * bi1;
      pc2 <= ar1 * bi1;
      pd2 <= ai1 * mx1;
      pe2 <= br1 * br1;
      pf2 <= bi1 * bi1;
    end
  end

  // ---------------- stage 3: sums and simple operations
  logic               v3;
  cau_func_t          fn3;
  logic signed [15:0] ar3, ai3, sc3;
  logic signed [33:0] sr3, si3, sr_n, si_n;
  logic        [31:0] den3;
  logic signed [16:0] dr3, di3, dr_n, di_n;
  logic               eq3, az3;

  assign rdy3 = !v3 || rdy4;

  always_comb begin
    sr_n = 34'(pa2);
    si_n = 34'(pd2);
    dr_n = '0;
    di_n = '0;
    case (fn2)
      FN_MUL: begin
        sr_n = 34'(pa2) - 34'(pb2);
        si_n = 34'(pc2) + 34'(pd2);
      end
      FN_DIV: begin
        sr_n = 34'(pa2) + 34'(pb2);
        si_n = 34'(pd2) - 34'(pc2);
      end
      default: ;
    endcase
    case (fn2)
      FN_ADD: begin
        dr_n = 17'(ar2) + 17'(br2);
        di_n = 17'(ai2) + 17'(bi2);
      end
      FN_ADDS: begin
        dr_n = 17'(ar2) + 17'(sc2);
        di_n = 17'(ai2);
      end
      FN_SUB: begin
        dr_n = 17'(ar2) - 17'(br2);
        di_n = 17'(ai2) - 17'(bi2);
      end
      FN_SUBS: begin
        dr_n = 17'(ar2) - 17'(sc2);
        di_n = 17'(ai2);
      end
      FN_CONJ: begin
        dr_n = 17'(ar2);
        di_n = -17'(ai2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      fn3  <= fn2;
      ar3  <= ar2;
      ai3  <= ai2;
      sc3  <= sc2;
      sr3  <= sr_n;
      si3  <= si_n;
      den3 <= $unsigned(pe2) + $unsigned(pf2);
      dr3  <= dr_n;
      di3  <= di_n;
      eq3  <= (ar2 == br2) && (ai2 == bi2);
      az3  <= (ar2 == 16'sd0) && (ai2 == 16'sd0);
    end
  end

  // ---------------- stage 4: rounding, saturation and divide setup
  logic               c_valid [NDIV+1];
  logic               c_ready [NDIV+1];
  cau_side_t          c_side  [NDIV+1];
  logic [NUM_W-1:0]   c_rem_re[NDIV+1];
  logic [NUM_W-1:0]   c_rem_im[NDIV+1];
  logic [DEN_W-1:0]   c_den   [NDIV+1];
  logic [QW:0]        c_q_re  [NDIV+1];
  logic [QW:0]        c_q_im  [NDIV+1];

  cau_side_t          side_n;
  logic [NUM_W-1:0]   nre_n, nim_n;
  logic [DEN_W-1:0]   den_n;
  logic signed [33:0] tr, ti, wr, wi;
  logic [31:0]        mr, mi;
  logic [15:0]        ma_r, ma_i, ms;

  assign rdy4 = !c_valid[0] || c_ready[0];

  always_comb begin
    side_n = '0;
    nre_n  = '0;
    nim_n  = '0;
    den_n  = '0;
    // truncation toward zero of the products
    tr = sr3 + ((sr3 < 0) ? $signed(RND) : 34'sd0);
    ti = si3 + ((si3 < 0) ? $signed(RND) : 34'sd0);
    wr = tr >>> FRAC_BITS;
    wi = ti >>> FRAC_BITS;
    mr = 32'((sr3 < 0) ? -sr3 : sr3);
    mi = 32'((si3 < 0) ? -si3 : si3);
    ma_r = (ar3 < 0) ? 16'(-ar3) : 16'(ar3);
    ma_i = (ai3 < 0) ? 16'(-ai3) : 16'(ai3);
    ms   = (sc3 < 0) ? 16'(-sc3) : 16'(sc3);
    case (fn3)
      FN_ADD, FN_ADDS, FN_SUB, FN_SUBS, FN_CONJ: begin
        side_n.res_re   = sat16(34'(dr3));
        side_n.res_im   = sat16(34'(di3));
        side_n.overflow = is_sat(34'(dr3)) || is_sat(34'(di3));
      end
      FN_MUL, FN_MULS: begin
        side_n.res_re   = sat16(wr);
        side_n.res_im   = sat16(wi);
        side_n.overflow = is_sat(wr) || is_sat(wi);
      end
      FN_DIV: begin
        if (!az3) begin
          if (den3 == '0) begin
            side_n.div_zero = 1'b1;
          end else begin
            side_n.is_div = 1'b1;
            side_n.neg_re = sr3 < 0;
            side_n.neg_im = si3 < 0;
            nre_n = NUM_W'(mr) << FRAC_BITS;
            nim_n = NUM_W'(mi) << FRAC_BITS;
            den_n = den3;
          end
        end
      end
      FN_DIVS: begin
        if (!az3) begin
          if (sc3 == 16'sd0) begin
            side_n.div_zero = 1'b1;
          end else begin
            side_n.is_div = 1'b1;
            side_n.neg_re = (ar3 < 0) ^ (sc3 < 0);
            side_n.neg_im = (ai3 < 0) ^ (sc3 < 0);
            nre_n = NUM_W'(ma_r) << FRAC_BITS;
            nim_n = NUM_W'(ma_i) << FRAC_BITS;
            den_n = DEN_W'(ms);
          end
        end
      end
      FN_EQ: begin
        side_n.is_equal = eq3;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (rdy4) begin
      c_valid[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      c_side[0]   <= side_n;
      c_rem_re[0] <= nre_n;
      c_rem_im[0] <= nim_n;
      c_den[0]    <= den_n;
      c_q_re[0]   <= '0;
      c_q_im[0]   <= '0;
    end
  end

  // ---------------- divider: one quotient bit per stage, overflow bit first
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    cau_div_step #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QW    (QW),
      .SHIFT (QW - i)
    ) u_step (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (c_valid[i]),
      .in_ready   (c_ready[i]),
      .in_side    (c_side[i]),
      .in_rem_re  (c_rem_re[i]),
      .in_rem_im  (c_rem_im[i]),
      .in_den     (c_den[i]),
      .in_q_re    (c_q_re[i]),
      .in_q_im    (c_q_im[i]),
      .out_valid  (c_valid[i+1]),
      .out_ready  (c_ready[i+1]),
      .out_side   (c_side[i+1]),
      .out_rem_re (c_rem_re[i+1]),
      .out_rem_im (c_rem_im[i+1]),
      .out_den    (c_den[i+1]),
      .out_q_re   (c_q_re[i+1]),
      .out_q_im   (c_q_im[i+1])
    );
  end

  // ---------------- output register: sign and saturate quotients
  cau_side_t          fs;
  logic [QW:0]        fq_re, fq_im;
  logic               st_re, st_im;
  logic signed [15:0] o_re, o_im;
  logic               rdy_o;

  assign fs    = c_side[NDIV];
  assign fq_re = c_q_re[NDIV];
  assign fq_im = c_q_im[NDIV];
  assign rdy_o = !m_tvalid || m_tready;
  assign c_ready[NDIV] = rdy_o;

  always_comb begin
    st_re = fq_re[QW] || (fs.neg_re ? (fq_re[QW-1:0] > 17'd32768)
                                    : (fq_re[QW-1:0] > 17'd32767));
    st_im = fq_im[QW] || (fs.neg_im ? (fq_im[QW-1:0] > 17'd32768)
                                    : (fq_im[QW-1:0] > 17'd32767));
    o_re = fs.res_re;
    o_im = fs.res_im;
    if (fs.is_div) begin
      if (st_re) o_re = fs.neg_re ? -16'sd32768 : 16'sd32767;
      else       o_re = fs.neg_re ? -$signed(16'(fq_re)) : $signed(16'(fq_re));
      if (st_im) o_im = fs.neg_im ? -16'sd32768 : 16'sd32767;
      else       o_im = fs.neg_im ? -$signed(16'(fq_im)) : $signed(16'(fq_im));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy_o) begin
      m_tvalid <= c_valid[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && c_valid[NDIV]) begin
      m_tdata <= {5'd0,
                  fs.overflow || (fs.is_div && (st_re || st_im)),
                  fs.div_zero, fs.is_equal, o_im, o_re};
    end
  end

endmodule

`default_nettype wire

[verif/tb_complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// tb_complex_arith_unit
// Streams complex ALU requests through the unit under random idling and
// backpressure, predicts each result in fixed point and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_complex_arith_unit;
  import cau_pkg::*;

  localparam int FRAC = 8;
  localparam int WATCHDOG_MAX = 20000;
  localparam int HOLD_OFF_LEN = 200;

  typedef struct packed {
    logic signed [15:0] scalar;
    logic signed [15:0] b_im;
    logic signed [15:0] b_re;
    logic signed [15:0] a_im;
    logic signed [15:0] a_re;
    logic [3:0]         func;
  } cau_req_t;

  typedef struct packed {
    logic               overflow;
    logic               div_zero;
    logic               is_equal;
    logic signed [15:0] res_im;
    logic signed [15:0] res_re;
  } cau_res_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  cau_req_t pending_reqs[$];
  cau_res_t expected_results[$];
  int       error_count = 0;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_off_cycles;
  bit       hold_off_req;
  bit       hold_off_taken;
  int       idle_cycles;
  bit       stim_done;

  complex_arith_unit #(.FRAC_BITS(FRAC)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // saturate to 16 bits, flag on clip
  function automatic logic signed [15:0] clip16(longint v, inout logic ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 16'sd32767;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  // truncate fraction bits toward zero
  function automatic longint trunc_frac(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = mag >>> FRAC;
    return (v < 0) ? -mag : mag;
  endfunction

  // expected result of one request
  function automatic cau_res_t alu_result(cau_req_t r);
    longint ar, ai, br, bi, sc, rr, ri, den;
    logic   ovf;
    cau_res_t o;
    ar = longint'(r.a_re); ai = longint'(r.a_im);
    br = longint'(r.b_re); bi = longint'(r.b_im); sc = longint'(r.scalar);
    rr = 0; ri = 0; ovf = 1'b0;
    o = '0;
    case (r.func)
      FN_ADD:  begin rr = ar + br; ri = ai + bi; end
      FN_ADDS: begin rr = ar + sc; ri = ai; end
      FN_SUB:  begin rr = ar - br; ri = ai - bi; end
      FN_SUBS: begin rr = ar - sc; ri = ai; end
      FN_MUL: begin
        rr = trunc_frac(ar * br - ai * bi);
        ri = trunc_frac(ar * bi + ai * br);
      end
      FN_MULS: begin
        rr = trunc_frac(ar * sc);
        ri = trunc_frac(ai * sc);
      end
      FN_DIV: begin
        den = br * br + bi * bi;
        if (ar == 0 && ai == 0) begin
        end else if (den == 0) begin
          o.div_zero = 1'b1;
        end else begin
          rr = ((ar * br + ai * bi) * (64'sd1 << FRAC)) / den;
          ri = ((ai * br - ar * bi) * (64'sd1 << FRAC)) / den;
        end
      end
      FN_DIVS: begin
        if (ar == 0 && ai == 0) begin
        end else if (sc == 0) begin
          o.div_zero = 1'b1;
        end else begin
          rr = (ar * (64'sd1 << FRAC)) / sc;
          ri = (ai * (64'sd1 << FRAC)) / sc;
        end
      end
      FN_CONJ: begin rr = ar; ri = -ai; end
      FN_EQ:   o.is_equal = (ar == br) && (ai == bi);
      default: ;
    endcase
    o.res_re = clip16(rr, ovf);
    o.res_im = clip16(ri, ovf);
    o.overflow = ovf;
    return o;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic push_req(logic [3:0] f, logic [15:0] ar, logic [15:0] ai,
                          logic [15:0] br, logic [15:0] bi, logic [15:0] sc);
    cau_req_t r;
    r.func = f; r.a_re = ar; r.a_im = ai; r.b_re = br; r.b_im = bi; r.scalar = sc;
    pending_reqs.push_back(r);
  endtask

  task automatic push_random(int n);
    logic [15:0] ar, ai;
    repeat (n) begin
      ar = rand_word();
      ai = rand_word();
      // equality hits need B close to A
      if ($urandom_range(0, 3) == 0)
        push_req(4'($urandom_range(0, 15)), ar, ai, ar,
                 ($urandom_range(0, 1) ? ai : rand_word()), rand_word());
      else
        push_req(4'($urandom_range(0, 12)), ar, ai, rand_word(), rand_word(), rand_word());
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, pending_reqs.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver readiness, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready        <= 1'b0;
      hold_off_cycles <= 0;
      hold_off_taken  <= 1'b0;
    end else if (hold_off_req && !hold_off_taken) begin
      hold_off_taken  <= 1'b1;
      hold_off_cycles <= HOLD_OFF_LEN;
      m_tready        <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: predict on request, compare on result
  always @(posedge clk) begin
    cau_res_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_results.push_back(alu_result(cau_req_t'(s_tdata[83:0])));
      if (m_tvalid && m_tready) begin
        got = cau_res_t'(m_tdata[34:0]);
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.res_re !== want.res_re)
            report_mismatch("res_re", int'(got.res_re), int'(want.res_re));
          if (got.res_im !== want.res_im)
            report_mismatch("res_im", int'(got.res_im), int'(want.res_im));
          if (got.is_equal !== want.is_equal)
            report_mismatch("is_equal", int'(got.is_equal), int'(want.is_equal));
          if (got.div_zero !== want.div_zero)
            report_mismatch("div_zero", int'(got.div_zero), int'(want.div_zero));
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", int'(got.overflow), int'(want.overflow));
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (!stim_done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    stim_done = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: every opcode, extremes and special cases
    push_req(FN_ADD,  16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h0);
    push_req(FN_ADDS, 16'h7fff, 16'h1234, 16'h0, 16'h0, 16'h7fff);
    push_req(FN_SUB,  16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h0);
    push_req(FN_SUBS, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h7fff);
    push_req(FN_MUL,  16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0);
    push_req(FN_MUL,  16'hff80, 16'h0040, 16'h0180, 16'hff00, 16'h0);
    push_req(FN_MULS, 16'h7fff, 16'h8000, 16'h0, 16'h0, 16'h8000);
    push_req(FN_MULS, 16'hffff, 16'h0001, 16'h0, 16'h0, 16'h0080);
    push_req(FN_DIV,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0);
    push_req(FN_DIV,  16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0);
    push_req(FN_DIV,  16'h8000, 16'h7fff, 16'h0001, 16'h0000, 16'h0);
    push_req(FN_DIV,  16'h0300, 16'hfe00, 16'h0100, 16'h0200, 16'h0);
    push_req(FN_DIV,  16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h0);
    push_req(FN_DIVS, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0000);
    push_req(FN_DIVS, 16'h0000, 16'h0001, 16'h0, 16'h0, 16'h0000);
    push_req(FN_DIVS, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'hffff);
    push_req(FN_DIVS, 16'hfd00, 16'h0500, 16'h0, 16'h0, 16'h0300);
    push_req(FN_CONJ, 16'h1234, 16'h8000, 16'h0, 16'h0, 16'h0);
    push_req(FN_CONJ, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h0);
    push_req(FN_EQ,   16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0);
    push_req(FN_EQ,   16'h8000, 16'h7fff, 16'h8000, 16'h7ffe, 16'h0);
    push_req(4'd10,   16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    push_req(4'd15,   16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555);
    wait_drained();

    // random phases: none, sender idle, receiver stall, both
    send_idle_pct = 0;  recv_stall_pct = 0;  push_random(400); wait_drained();
    send_idle_pct = 59; recv_stall_pct = 0;  push_random(300); wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 59; push_random(300); wait_drained();
    send_idle_pct = 34; recv_stall_pct = 34; push_random(300); wait_drained();

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0; recv_stall_pct = 20;
    hold_off_req = 1'b1;
    push_random(330);
    wait_drained();

    stim_done = 1'b1;
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/cau_pkg.sv
design/cau_div_step.sv
design/complex_arith_unit.sv
verif/tb_complex_arith_unit.sv
